@@ hw/rtl/sgrpm_pkg.sv @@
package sgrpm_pkg;

    localparam int SAMPLE_BITS          = 24;
    localparam int GAIN_W               = 16;
    localparam int EFF_W                = 2 * GAIN_W;
    localparam int ROUND_SHIFT          = 28;
    localparam int METER_W              = 23;
    localparam int WEIGHT_W             = 16;
    localparam int CFG_ADDR_W           = 2;
    localparam int CFG_DATA_W           = 16;
    localparam int IN_DATA_W            = 64;
    localparam int OUT_DATA_W           = 96;
    localparam int DEF_MAX_BLOCK_FRAMES = 4096;

    localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd16384;
    localparam logic [METER_W-1:0]  METER_MAX  = 23'h7FFFFF;
    localparam logic [WEIGHT_W-1:0] W_OLD      = 16'd58982;
    localparam logic [WEIGHT_W-1:0] W_NEW      = 16'd6554;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN    = 2'd0,
        REG_MUTE    = 2'd1,
        REG_CAPTURE = 2'd2
    } cfg_reg_t;

endpackage

@@ hw/rtl/stereo_gain_rms_peak_meter_unit.sv @@
// path: a request passes S_MUL, S_MIX, S_SQ and S_ACC to S_DONE, where its result is
// registered; a block close with capture on also takes the smoothing steps S_SM1 and S_SM2,
// preceded by the divide and square root in the root unit when frames were counted
// flow: one request in flight; the next is accepted only after the last result is
// registered, which waits for m_tready while a previous result is still held
// reset: rst_n sets unity gain, unmuted, capture off; clears accumulators, meters, output valid
module stereo_gain_rms_peak_meter_unit
#(
    parameter int MAX_BLOCK_FRAMES = sgrpm_pkg::DEF_MAX_BLOCK_FRAMES
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [sgrpm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sgrpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sgrpm_pkg::IN_DATA_W-1:0]      s_tdata,   // left_sample, right_sample, gain_cv
    input  logic                                 s_tuser,   // frame_present
    input  logic                                 s_tlast,   // last_of_block
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sgrpm_pkg::OUT_DATA_W-1:0]     m_tdata,   // out_left, out_right, rms_level, peak_level
    output logic                                 m_tuser    // meters_updated
);

    localparam int SB     = sgrpm_pkg::SAMPLE_BITS;
    localparam int MW     = sgrpm_pkg::METER_W;
    localparam int GW     = sgrpm_pkg::GAIN_W;
    localparam int CNT_W  = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int SQ_W   = 2 * SB - 1;
    localparam int SUM_W  = 2 * SB - 2 + CNT_W;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int SM_W   = sgrpm_pkg::WEIGHT_W + MW;
    localparam int ACC_W  = SM_W + 1;
    localparam int PAD_W  = sgrpm_pkg::OUT_DATA_W - 2 * SB - 2 * MW;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCK_FRAMES);
    localparam logic [ACC_W-1:0] SM_ROUND = ACC_W'(32768);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MIX,
        S_SQ,
        S_ACC,
        S_ROOT,
        S_SM1,
        S_SM2,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [GW-1:0]               gain_reg;
    logic                        mute_reg;
    logic                        capture_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SB-1:0]               peak_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [MW-1:0]               rms_meter_reg;
    logic [MW-1:0]               peak_meter_reg;
    logic                        updated_reg;
    logic                        m_valid_reg;
    logic [sgrpm_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic                        m_user_reg;

    logic [sgrpm_pkg::EFF_W-1:0] eff_reg;
    sgrpm_pkg::sample_t          l_in_reg;
    sgrpm_pkg::sample_t          r_in_reg;
    logic                        present_reg;
    logic                        last_reg;
    sgrpm_pkg::sample_t          out_l_reg;
    sgrpm_pkg::sample_t          out_r_reg;
    logic [SB-1:0]               a_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [MW-1:0]               pk_raw_reg;
    logic [MW-1:0]               rms_raw_reg;
    logic [SM_W-1:0]             rms_old_reg;
    logic [SM_W-1:0]             rms_new_reg;
    logic [SM_W-1:0]             pk_old_reg;
    logic [SM_W-1:0]             pk_new_reg;

    logic                        accept;
    logic                        lane_load;
    sgrpm_pkg::sample_t          lane_l;
    sgrpm_pkg::sample_t          lane_r;
    logic signed [SB:0]          mix;
    logic signed [SB:0]          mono;
    logic [SB:0]                 mono_abs;
    logic                        count_en;
    logic [SUM_W-1:0]            sum_tot;
    logic [CNT_W-1:0]            cnt_tot;
    logic [SB-1:0]               peak_tot;
    logic [MW-1:0]               peak_clamp;
    logic                        root_start;
    logic                        root_done;
    logic [ROOT_W-1:0]           root_val;
    logic [MW-1:0]               root_clamp;
    logic [ACC_W-1:0]            rms_acc;
    logic [ACC_W-1:0]            pk_acc;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign lane_load = (state_reg == S_MUL);

    sgrpm_gain_lane u_lane_l
    (
        .clk    (clk),
        .load   (lane_load),
        .sample (l_in_reg),
        .eff    (eff_reg),
        .gained (lane_l)
    );

    sgrpm_gain_lane u_lane_r
    (
        .clk    (clk),
        .load   (lane_load),
        .sample (r_in_reg),
        .eff    (eff_reg),
        .gained (lane_r)
    );

    sgrpm_root_unit
    #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    )
    u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (sum_tot),
        .divisor  (cnt_tot),
        .done     (root_done),
        .root     (root_val)
    );

    // merge of the two lanes: floor((l+r)/2) and its magnitude
    always_comb
    begin
        mix      = {lane_l[SB-1], lane_l} + {lane_r[SB-1], lane_r};
        mono     = mix >>> 1;
        mono_abs = mono[SB] ? ((SB+1)'(0) - mono) : mono;
    end

    always_comb
    begin
        count_en   = capture_reg && present_reg && (cnt_reg < CNT_MAX);
        sum_tot    = sum_reg + (count_en ? SUM_W'(sq_reg) : '0);
        cnt_tot    = cnt_reg + CNT_W'(count_en);
        peak_tot   = (count_en && (a_reg > peak_reg)) ? a_reg : peak_reg;
        peak_clamp = (peak_tot > SB'(sgrpm_pkg::METER_MAX)) ? sgrpm_pkg::METER_MAX
                                                            : peak_tot[MW-1:0];
        root_start = (state_reg == S_ACC) && last_reg && capture_reg && (cnt_tot != '0);
        root_clamp = (root_val > ROOT_W'(sgrpm_pkg::METER_MAX)) ? sgrpm_pkg::METER_MAX
                                                                : root_val[MW-1:0];
        rms_acc    = ACC_W'(rms_old_reg) + ACC_W'(rms_new_reg) + SM_ROUND;
        pk_acc     = ACC_W'(pk_old_reg) + ACC_W'(pk_new_reg) + SM_ROUND;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            eff_reg     <= mute_reg ? '0 : (sgrpm_pkg::EFF_W'(gain_reg)
                                           * sgrpm_pkg::EFF_W'(s_tdata[2*SB +: GW]));
            l_in_reg    <= s_tdata[SB-1:0];
            r_in_reg    <= s_tdata[2*SB-1:SB];
            present_reg <= s_tuser;
            last_reg    <= s_tlast;
        end
        if (state_reg == S_MIX)
        begin
            out_l_reg <= (capture_reg && present_reg) ? lane_l : '0;
            out_r_reg <= (capture_reg && present_reg) ? lane_r : '0;
            a_reg     <= mono_abs[SB-1:0];
        end
        if (state_reg == S_SQ)
            sq_reg <= SQ_W'(a_reg) * SQ_W'(a_reg);
        if (state_reg == S_ACC)
        begin
            pk_raw_reg  <= peak_clamp;
            rms_raw_reg <= '0;
        end
        if ((state_reg == S_ROOT) && root_done)
            rms_raw_reg <= root_clamp;
        if (state_reg == S_SM1)
        begin
            rms_old_reg <= SM_W'(sgrpm_pkg::W_OLD) * SM_W'(rms_meter_reg);
            rms_new_reg <= SM_W'(sgrpm_pkg::W_NEW) * SM_W'(rms_raw_reg);
            pk_old_reg  <= SM_W'(sgrpm_pkg::W_OLD) * SM_W'(peak_meter_reg);
            pk_new_reg  <= SM_W'(sgrpm_pkg::W_NEW) * SM_W'(pk_raw_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            gain_reg       <= sgrpm_pkg::GAIN_RESET;
            mute_reg       <= 1'b0;
            capture_reg    <= 1'b0;
            sum_reg        <= '0;
            peak_reg       <= '0;
            cnt_reg        <= '0;
            rms_meter_reg  <= '0;
            peak_meter_reg <= '0;
            updated_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_user_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (sgrpm_pkg::cfg_reg_t'(cfg_addr))
                    sgrpm_pkg::REG_GAIN:    gain_reg    <= cfg_wdata[GW-1:0];
                    sgrpm_pkg::REG_MUTE:    mute_reg    <= cfg_wdata[0];
                    sgrpm_pkg::REG_CAPTURE: capture_reg <= cfg_wdata[0];
                    default:                ;
                endcase
            end

            if (m_tready && (state_reg != S_DONE))
                m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_MIX;
                S_MIX:
                    state_reg <= S_SQ;
                S_SQ:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    updated_reg <= last_reg && capture_reg;
                    if (last_reg)
                    begin
                        sum_reg  <= '0;
                        peak_reg <= '0;
                        cnt_reg  <= '0;
                        if (!capture_reg)
                            state_reg <= S_DONE;
                        else if (cnt_tot != '0)
                            state_reg <= S_ROOT;
                        else
                            state_reg <= S_SM1;
                    end
                    else
                    begin
                        sum_reg   <= sum_tot;
                        peak_reg  <= peak_tot;
                        cnt_reg   <= cnt_tot;
                        state_reg <= S_DONE;
                    end
                end
                S_ROOT:
                begin
                    if (root_done)
                        state_reg <= S_SM1;
                end
                S_SM1:
                    state_reg <= S_SM2;
                S_SM2:
                begin
                    rms_meter_reg  <= rms_acc[SM_W-1:sgrpm_pkg::WEIGHT_W];
                    peak_meter_reg <= pk_acc[SM_W-1:sgrpm_pkg::WEIGHT_W];
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{PAD_W{1'b0}}, peak_meter_reg, rms_meter_reg,
                                        out_r_reg, out_l_reg};
                        m_user_reg  <= updated_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("frame count beyond block limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second request taken while one is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == S_ROOT))
        else $error("root result arrived outside block close");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((rms_meter_reg != $past(rms_meter_reg)) || (peak_meter_reg != $past(peak_meter_reg)))
        |-> ($past(state_reg) == S_SM2))
        else $error("meter changed outside the smoothing step");

endmodule

@@ hw/rtl/sgrpm_gain_lane.sv @@
module sgrpm_gain_lane
(
    input  logic                                 clk,
    input  logic                                 load,
    input  sgrpm_pkg::sample_t                   sample,
    input  logic [sgrpm_pkg::EFF_W-1:0]          eff,
    output sgrpm_pkg::sample_t                   gained
);

    localparam int SB     = sgrpm_pkg::SAMPLE_BITS;
    localparam int PROD_W = SB + sgrpm_pkg::EFF_W;
    localparam int R_W    = PROD_W + 1 - sgrpm_pkg::ROUND_SHIFT;

    localparam logic [PROD_W:0]  HALF_LSB = (PROD_W+1)'(1) << (sgrpm_pkg::ROUND_SHIFT - 1);
    localparam logic [R_W-1:0]   POS_LIM  = R_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [R_W-1:0]   NEG_LIM  = R_W'(64'd1 << (SB - 1));

    logic [SB-1:0]     mag;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W:0]   rounded;
    logic [R_W-1:0]    r;

    assign mag = sample[SB-1] ? (~sample + 1'b1) : sample;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg  <= sample[SB-1];
            prod_reg <= PROD_W'(mag) * PROD_W'(eff);
        end
    end

    // round half away from zero, then saturate
    always_comb
    begin
        rounded = {1'b0, prod_reg} + HALF_LSB;
        r       = rounded[PROD_W:sgrpm_pkg::ROUND_SHIFT];
        if (neg_reg)
        begin
            if (r > NEG_LIM)
                gained = {1'b1, {(SB-1){1'b0}}};
            else
                gained = sgrpm_pkg::sample_t'(SB'(0) - r[SB-1:0]);
        end
        else
        begin
            if (r > POS_LIM)
                gained = {1'b0, {(SB-1){1'b1}}};
            else
                gained = sgrpm_pkg::sample_t'(r[SB-1:0]);
        end
    end

endmodule

@@ hw/rtl/sgrpm_root_unit.sv @@
module sgrpm_root_unit
#(
    parameter int SUM_W = 59,
    parameter int CNT_W = 13
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              dividend,
    input  logic [CNT_W-1:0]              divisor,
    output logic                          done,
    output logic [(SUM_W+1)/2-1:0]        root
);

    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int IT_W   = $clog2(SUM_W);

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT
    } rstate_t;

    rstate_t            state_reg;
    logic [SUM_W-1:0]   num_reg;
    logic [CNT_W-1:0]   den_reg;
    logic [CNT_W-1:0]   drem_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   srem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [IT_W-1:0]    it_reg;
    logic               done_reg;

    logic [CNT_W:0]     dtrial;
    logic [CNT_W:0]     dsub;
    logic               dfit;
    logic [CNT_W-1:0]   drem_next;
    logic [REM_W-1:0]   stry;
    logic [REM_W-1:0]   strial;
    logic               sfit;

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        dtrial    = {drem_reg, num_reg[SUM_W-1]};
        dsub      = dtrial - {1'b0, den_reg};
        dfit      = dtrial >= {1'b0, den_reg};
        drem_next = dfit ? dsub[CNT_W-1:0] : dtrial[CNT_W-1:0];
    end

    // digit-by-digit square root, two radicand bits per cycle
    always_comb
    begin
        stry   = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        strial = REM_W'({root_reg, 2'b01});
        sfit   = stry >= strial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            num_reg   <= '0;
            den_reg   <= '0;
            drem_reg  <= '0;
            rad_reg   <= '0;
            srem_reg  <= '0;
            root_reg  <= '0;
            it_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                R_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        num_reg   <= dividend;
                        den_reg   <= divisor;
                        drem_reg  <= '0;
                        it_reg    <= IT_W'(SUM_W - 1);
                        state_reg <= R_DIV;
                    end
                end
                R_DIV:
                begin
                    num_reg  <= {num_reg[SUM_W-2:0], dfit};
                    drem_reg <= drem_next;
                    if (it_reg == '0)
                    begin
                        rad_reg   <= RAD_W'({num_reg[SUM_W-2:0], dfit});
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        it_reg    <= IT_W'(ROOT_W - 1);
                        state_reg <= R_SQRT;
                    end
                    else
                        it_reg <= it_reg - 1'b1;
                end
                R_SQRT:
                begin
                    srem_reg <= sfit ? (stry - strial) : stry;
                    root_reg <= {root_reg[ROOT_W-2:0], sfit};
                    rad_reg  <= rad_reg << 2;
                    if (it_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                    else
                        it_reg <= it_reg - 1'b1;
                end
                default:
                    state_reg <= R_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
